>>> rtl/pattern_occurrence_counter_core_macros.svh
// assertion macros for the pattern occurrence counter
// expects clk and rst_n in the scope of use
`ifndef PATTERN_OCCURRENCE_COUNTER_CORE_MACROS_SVH
`define PATTERN_OCCURRENCE_COUNTER_CORE_MACROS_SVH

// same-cycle implication
`define POC_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("poc assertion failed");

// next-cycle implication
`define POC_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("poc assertion failed");

`endif

>>> rtl/poc_pkg.sv
// shared types, constants and helpers for the pattern occurrence counter
// no dependencies
`timescale 1ns / 1ps

package poc_pkg;

    localparam int MAX_PATTERN     = 32;
    localparam int COUNT_WIDTH     = 20;
    localparam int LETTER_W        = 5;
    localparam int LETTER_SLOTS    = 32;
    localparam int LETTERS_PER_REG = 8;
    localparam int PAT_REG_COUNT   = 4;
    localparam int PAT_REG_W       = LETTERS_PER_REG * LETTER_W;
    localparam int PAT_FLAT_W      = LETTER_SLOTS * LETTER_W;
    localparam int PAT_LIM         = (MAX_PATTERN < LETTER_SLOTS) ? MAX_PATTERN : LETTER_SLOTS;
    localparam int LEN_W           = 6;
    localparam int SLOT_IDX_W      = $clog2(LETTER_SLOTS);
    localparam int APB_DATA_W      = 64;
    localparam int APB_ADDR_W      = 6;
    localparam int REG_IDX_W       = 3;

    localparam logic [REG_IDX_W-1:0] REG_PATTERN_LEN = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LETTERS_0   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LETTERS_1   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LETTERS_2   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LETTERS_3   = 3'd4;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    typedef struct packed {
        logic                valid;
        logic [LETTER_W-1:0] letter;
    } cell_data_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctl_t;

    typedef struct packed {
        logic [LEN_W-1:0]      len;
        logic [PAT_FLAT_W-1:0] pattern;
    } cfg_t;

    function automatic logic [LETTER_W-1:0] pattern_letter(
        input logic [PAT_FLAT_W-1:0] flat,
        input logic [SLOT_IDX_W-1:0] idx
    );
        logic [LETTER_W-1:0] res;
        res = flat[idx * LETTER_W +: LETTER_W];
        return res;
    endfunction

endpackage

>>> rtl/poc_in_if.sv
// input channel: text letters with end-of-text mark
// depends on poc_pkg
`timescale 1ns / 1ps

interface poc_in_if
    import poc_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [LETTER_W-1:0] letter;
    logic                final_letter;

    modport source (output valid, output letter, output final_letter, input ready);
    modport sink   (input valid, input letter, input final_letter, output ready);
endinterface

>>> rtl/poc_out_if.sv
// output channel: match flag, running count, end-of-text echo
// depends on poc_pkg
`timescale 1ns / 1ps

interface poc_out_if
    import poc_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic                   match_end;
    logic [COUNT_WIDTH-1:0] match_count;
    logic                   text_done;

    modport source (output valid, output match_end, output match_count, output text_done,
                    input ready);
    modport sink   (input valid, input match_end, input match_count, input text_done,
                    output ready);
endinterface

>>> rtl/poc_cfg.sv
// apb register file: pattern length and packed pattern letters
// depends on poc_pkg
`timescale 1ns / 1ps

module poc_cfg
    import poc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [LEN_W-1:0]     len_reg;
    logic [PAT_REG_W-1:0] pat_reg [PAT_REG_COUNT];
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [LEN_W-1:0]     eff_len;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= LEN_W'(1);
            for (int i = 0; i < PAT_REG_COUNT; i++)
            begin
                pat_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_PATTERN_LEN: len_reg    <= pwdata[LEN_W-1:0];
                REG_LETTERS_0:   pat_reg[0] <= pwdata[PAT_REG_W-1:0];
                REG_LETTERS_1:   pat_reg[1] <= pwdata[PAT_REG_W-1:0];
                REG_LETTERS_2:   pat_reg[2] <= pwdata[PAT_REG_W-1:0];
                REG_LETTERS_3:   pat_reg[3] <= pwdata[PAT_REG_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_PATTERN_LEN: prdata = APB_DATA_W'(len_reg);
            REG_LETTERS_0:   prdata = APB_DATA_W'(pat_reg[0]);
            REG_LETTERS_1:   prdata = APB_DATA_W'(pat_reg[1]);
            REG_LETTERS_2:   prdata = APB_DATA_W'(pat_reg[2]);
            REG_LETTERS_3:   prdata = APB_DATA_W'(pat_reg[3]);
            default:         prdata = '0;
        endcase
    end

    // zero length acts as one, long lengths clamp
    always_comb
    begin
        if (len_reg == '0)
            eff_len = LEN_W'(1);
        else if (len_reg > LEN_W'(PAT_LIM))
            eff_len = LEN_W'(PAT_LIM);
        else
            eff_len = len_reg;
    end

    assign cfg.len     = eff_len;
    assign cfg.pattern = {pat_reg[3], pat_reg[2], pat_reg[1], pat_reg[0]};

endmodule

>>> rtl/poc_cell.sv
// one window cell: holds a letter and its valid bit, compares against a pattern letter
// depends on poc_pkg
`timescale 1ns / 1ps

module poc_cell
    import poc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cell_ctl_t           ctl,
    input  cell_data_t          data_in,
    input  logic [LETTER_W-1:0] pat_letter,
    input  logic                in_use,
    output cell_data_t          data_out,
    output logic                match
);

    cell_data_t data_reg;
    cell_data_t data_next;

    // compare the value shifting in this cycle
    assign match = !in_use || (data_in.valid && (data_in.letter == pat_letter));

    always_comb
    begin
        data_next = data_reg;
        if (ctl.shift)
            data_next = ctl.clear ? cell_data_t'('0) : data_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            data_reg <= '0;
        else
            data_reg <= data_next;
    end

    assign data_out = data_reg;

endmodule

>>> rtl/pattern_occurrence_counter_core.sv
// latency: the result of an item is registered at the edge that accepts it, valid next cycle
// throughput: one item per cycle unless output stalls; window shift and full parallel compare
// close at accept; a waiting result the output takes in the same cycle does not block input
// reset: window, valid bits, count and output valid clear; pattern_len resets to 1, letters to 0
// depends on poc_pkg, poc_in_if, poc_out_if, poc_cfg, poc_cell and the macros header
`timescale 1ns / 1ps
`include "pattern_occurrence_counter_core_macros.svh"

module pattern_occurrence_counter_core
    import poc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    poc_in_if.sink                item_in,
    poc_out_if.source             item_out
);

    cfg_t       cfg;
    cell_ctl_t  ctl;
    cell_data_t chain [MAX_PATTERN+1];
    logic [MAX_PATTERN-1:0] match_vec;

    logic                   in_acc;
    logic                   hit;
    logic [COUNT_WIDTH-1:0] occ_reg;
    logic [COUNT_WIDTH-1:0] occ_next;
    logic [COUNT_WIDTH-1:0] cnt_now;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   match_end_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic                   done_reg;

    poc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign item_in.ready = !out_valid_reg || item_out.ready;
    assign in_acc        = item_in.valid && item_in.ready;

    assign ctl.shift = in_acc;
    assign ctl.clear = item_in.final_letter;

    assign chain[0].valid  = 1'b1;
    assign chain[0].letter = item_in.letter;

    for (genvar k = 0; k < MAX_PATTERN; k++)
    begin : g_cell
        logic                  in_use;
        logic [LEN_W:0]        pat_pos;
        logic [LETTER_W-1:0]   pat_letter;

        // cell k meets pattern letter len-1-k
        assign in_use     = {1'b0, cfg.len} > (LEN_W+1)'(k);
        assign pat_pos    = {1'b0, cfg.len} - (LEN_W+1)'(k + 1);
        assign pat_letter = pattern_letter(cfg.pattern, pat_pos[SLOT_IDX_W-1:0]);

        poc_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .data_in    (chain[k]),
            .pat_letter (pat_letter),
            .in_use     (in_use),
            .data_out   (chain[k+1]),
            .match      (match_vec[k])
        );
    end

    assign hit = &match_vec;

    // saturating occurrence count
    assign cnt_now = (hit && (occ_reg != COUNT_MAX)) ? occ_reg + COUNT_WIDTH'(1) : occ_reg;

    always_comb
    begin
        occ_next = occ_reg;
        if (in_acc)
            occ_next = item_in.final_letter ? '0 : cnt_now;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_acc)
            out_valid_next = 1'b1;
        else if (item_out.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            match_end_reg <= hit;
            count_reg     <= cnt_now;
            done_reg      <= item_in.final_letter;
        end
    end

    assign item_out.valid       = out_valid_reg;
    assign item_out.match_end   = match_end_reg;
    assign item_out.match_count = count_reg;
    assign item_out.text_done   = done_reg;

    `POC_ASSERT_NXT(a_acc_gives_result, in_acc, out_valid_reg)
    `POC_ASSERT_IMP(a_match_counted, out_valid_reg && match_end_reg, count_reg != '0)
    `POC_ASSERT_NXT(a_final_clears, in_acc && item_in.final_letter, occ_reg == '0 && !chain[1].valid)

endmodule

>>> verif/pattern_occurrence_counter_core_test.sv
// self-checking testbench for pattern_occurrence_counter_core: streams texts with random
// idling on both channels, programs patterns over apb and checks every result
// depends on poc_pkg, poc_in_if, poc_out_if and the core rtl
`timescale 1ns / 1ps

module pattern_occurrence_counter_core_test;
    import poc_pkg::*;

    localparam longint CYCLE_LIMIT  = 4000000;
    localparam int     PRINT_LIMIT  = 40;
    localparam int     RANDOM_ITEMS = 1400;
    localparam int     GAP_MAX      = 10;
    localparam int     DRAIN_CYCLES = 4;
    localparam int     PAT_IDX_W    = $clog2(PAT_REG_COUNT);

    localparam logic [REG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

    localparam logic [LETTER_W-1:0] LTR_A    = 5'd0;
    localparam logic [LETTER_W-1:0] LTR_B    = 5'd1;
    localparam logic [LETTER_W-1:0] LTR_C    = 5'd2;
    localparam logic [LETTER_W-1:0] LTR_Y    = 5'd24;
    localparam logic [LETTER_W-1:0] LTR_Z    = 5'd25;
    localparam logic [LETTER_W-1:0] CODE_26  = 5'd26;
    localparam logic [LETTER_W-1:0] CODE_TOP = 5'd31;

    typedef struct packed {
        logic                   match_end;
        logic [COUNT_WIDTH-1:0] match_count;
        logic                   text_done;
    } tally_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    poc_in_if  letter_if ();
    poc_out_if tally_if ();

    pattern_occurrence_counter_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .item_in  (letter_if),
        .item_out (tally_if)
    );

    // predictor state
    logic [LEN_W-1:0]     model_len;
    logic [PAT_REG_W-1:0] model_letters [PAT_REG_COUNT];
    logic [LETTER_W-1:0]  model_window [MAX_PATTERN];
    int                   model_filled;
    logic [COUNT_WIDTH-1:0] model_count;

    tally_t pending_tallies [$];
    int     err_count   = 0;
    int     src_gap_max = GAP_MAX;
    int     snk_gap_max = GAP_MAX;
    longint cycle_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= PRINT_LIMIT)
            $display("%0t ERROR: %s", $time, msg);
    endtask

    function automatic int effective_len(input logic [LEN_W-1:0] len);
        int n;
        n = int'(len);
        if (n == 0)
            n = 1;
        if (n > PAT_LIM)
            n = PAT_LIM;
        return n;
    endfunction

    function automatic logic [LETTER_W-1:0] pattern_slot(input int idx);
        logic [PAT_REG_W-1:0] reg_val;
        reg_val = model_letters[PAT_IDX_W'(idx / LETTERS_PER_REG)];
        return reg_val[(idx % LETTERS_PER_REG) * LETTER_W +: LETTER_W];
    endfunction

    function automatic void reset_model();
        int i;
        model_len = LEN_W'(1);
        for (i = 0; i < PAT_REG_COUNT; i++)
            model_letters[i] = '0;
        for (i = 0; i < MAX_PATTERN; i++)
            model_window[i] = '0;
        model_filled = 0;
        model_count  = '0;
    endfunction

    function automatic void apply_register(input logic [REG_IDX_W-1:0] idx,
                                           input logic [APB_DATA_W-1:0] value);
        if (idx == REG_PATTERN_LEN)
            model_len = value[LEN_W-1:0];
        else if (idx >= REG_LETTERS_0 && idx <= REG_LETTERS_3)
            model_letters[PAT_IDX_W'(idx - REG_LETTERS_0)] = value[PAT_REG_W-1:0];
    endfunction

    // shift the letter in, compare the newest letters with the pattern, count; clear all at end of text
    function automatic tally_t predict_tally(input logic [LETTER_W-1:0] letter, input logic last);
        tally_t t;
        int     n;
        int     i;
        logic   hit;
        for (i = MAX_PATTERN - 1; i > 0; i--)
            model_window[i] = model_window[i-1];
        model_window[0] = letter;
        if (model_filled < MAX_PATTERN)
            model_filled++;
        n   = effective_len(model_len);
        hit = (model_filled >= n);
        for (i = 0; i < n; i++)
            if (model_window[n-1-i] != pattern_slot(i))
                hit = 1'b0;
        if (hit && model_count != COUNT_MAX)
            model_count++;
        t.match_end   = hit;
        t.match_count = model_count;
        t.text_done   = last;
        if (last)
        begin
            for (i = 0; i < MAX_PATTERN; i++)
                model_window[i] = '0;
            model_filled = 0;
            model_count  = '0;
        end
        return t;
    endfunction

    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        apply_register(idx, value);
        @(posedge clk);
    endtask

    task automatic reg_read_check(input logic [REG_IDX_W-1:0] idx);
        logic [APB_DATA_W-1:0] want;
        want = '0;
        if (idx == REG_PATTERN_LEN)
            want[LEN_W-1:0] = model_len;
        else
            want[PAT_REG_W-1:0] = model_letters[PAT_IDX_W'(idx - REG_LETTERS_0)];
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 3'b000};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== want)
            report_mismatch($sformatf("register %0d read %h, want %h", idx, prdata, want));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_pattern(input logic [LEN_W-1:0] len, input logic [LETTER_W-1:0] l0,
                                   input logic [LETTER_W-1:0] l1, input logic [LETTER_W-1:0] l2);
        reg_write(REG_PATTERN_LEN, APB_DATA_W'(len));
        reg_write(REG_LETTERS_0, APB_DATA_W'({l2, l1, l0}));
    endtask

    task automatic send_letter(input logic [LETTER_W-1:0] letter, input logic last);
        int gap;
        gap = $urandom_range(src_gap_max, 0);
        if (gap > 0)
        begin
            letter_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        letter_if.valid        <= 1'b1;
        letter_if.letter       <= letter;
        letter_if.final_letter <= last;
        @(posedge clk);
        while (!letter_if.ready)
            @(posedge clk);
        pending_tallies.push_back(predict_tally(letter, last));
    endtask

    task automatic wait_idle();
        letter_if.valid <= 1'b0;
        while (pending_tallies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic check_tally();
        tally_t want;
        if (pending_tallies.size() == 0)
        begin
            report_mismatch("result with no item pending");
            return;
        end
        want = pending_tallies.pop_front();
        if (tally_if.match_end !== want.match_end)
            report_mismatch($sformatf("match_end %b, want %b",
                                      tally_if.match_end, want.match_end));
        if (tally_if.match_count !== want.match_count)
            report_mismatch($sformatf("match_count %0d, want %0d",
                                      tally_if.match_count, want.match_count));
        if (tally_if.text_done !== want.text_done)
            report_mismatch($sformatf("text_done %b, want %b",
                                      tally_if.text_done, want.text_done));
    endtask

    // result side: random stall per item, check at each accepted result
    initial
    begin
        int stall;
        tally_if.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = $urandom_range(snk_gap_max, 0);
            if (stall > 0)
            begin
                tally_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            tally_if.ready <= 1'b1;
            @(posedge clk);
            while (!tally_if.valid)
                @(posedge clk);
            check_tally();
        end
    end

    function automatic logic [LETTER_W-1:0] pick_letter(input int alpha);
        if ($urandom_range(15, 0) == 0)
            return LETTER_W'($urandom_range(CODE_TOP, 0));
        return LETTER_W'($urandom_range(alpha - 1, 0));
    endfunction

    // reset pattern is a single A
    task automatic test_reset_pattern();
        send_letter(LTR_A, 1'b0);
        send_letter(LTR_B, 1'b0);
        send_letter(LTR_A, 1'b1);
        wait_idle();
    endtask

    task automatic test_register_access();
        int r;
        for (r = REG_PATTERN_LEN; r <= REG_LETTERS_3; r++)
            reg_read_check(REG_IDX_W'(r));
        // all ones: length 63 and every letter code 31, upper data bits dropped
        for (r = REG_PATTERN_LEN; r <= REG_LETTERS_3; r++)
            reg_write(REG_IDX_W'(r), '1);
        for (r = REG_SPARE_FIRST; r <= REG_SPARE_LAST; r++)
            reg_write(REG_IDX_W'(r), '0);
        for (r = REG_PATTERN_LEN; r <= REG_LETTERS_3; r++)
            reg_read_check(REG_IDX_W'(r));
    endtask

    task automatic test_short_text_and_overlap();
        program_pattern(LEN_W'(3), LTR_A, LTR_B, LTR_A);
        send_letter(LTR_A, 1'b0);
        send_letter(LTR_B, 1'b1);
        send_letter(LTR_A, 1'b0);
        send_letter(LTR_B, 1'b0);
        send_letter(LTR_A, 1'b0);
        send_letter(LTR_B, 1'b0);
        send_letter(LTR_A, 1'b1);
        wait_idle();
    endtask

    task automatic test_zero_length();
        program_pattern(LEN_W'(0), LTR_Z, LTR_A, LTR_A);
        send_letter(LTR_Z, 1'b0);
        send_letter(LTR_Y, 1'b0);
        send_letter(LTR_Z, 1'b1);
        wait_idle();
    endtask

    task automatic test_high_codes();
        program_pattern(LEN_W'(2), CODE_TOP, CODE_26, LTR_A);
        send_letter(CODE_TOP, 1'b0);
        send_letter(CODE_26, 1'b0);
        send_letter(CODE_26, 1'b0);
        send_letter(CODE_TOP, 1'b0);
        send_letter(CODE_26, 1'b1);
        wait_idle();
    endtask

    // pattern change keeps the window and the count
    task automatic test_config_mid_text();
        program_pattern(LEN_W'(2), LTR_A, LTR_B, LTR_A);
        send_letter(LTR_A, 1'b0);
        wait_idle();
        program_pattern(LEN_W'(2), LTR_A, LTR_C, LTR_A);
        send_letter(LTR_C, 1'b0);
        send_letter(LTR_C, 1'b1);
        wait_idle();
    endtask

    task automatic test_random_texts();
        int                   sent;
        int                   alpha;
        int                   len_sel;
        int                   n;
        int                   texts;
        int                   t;
        int                   s;
        int                   text_len;
        logic                 keep_open;
        logic [LEN_W-1:0]     len_val;
        logic [PAT_REG_W-1:0] regv;
        logic [LETTER_W-1:0]  pat [PAT_LIM];
        logic [LETTER_W-1:0]  text [$];
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            wait_idle();
            case ($urandom_range(3, 0))
                0: begin src_gap_max = 0;       snk_gap_max = 0;       end
                1: begin src_gap_max = GAP_MAX; snk_gap_max = 0;       end
                2: begin src_gap_max = 0;       snk_gap_max = GAP_MAX; end
                default: begin src_gap_max = GAP_MAX; snk_gap_max = GAP_MAX; end
            endcase
            alpha   = ($urandom_range(7, 0) == 0) ? (CODE_TOP + 1) : $urandom_range(4, 1);
            len_sel = $urandom_range(15, 0);
            if (len_sel == 0)
                len_val = '0;
            else if (len_sel == 1)
                len_val = LEN_W'(PAT_LIM);
            else if (len_sel == 2)
                len_val = LEN_W'($urandom_range((1 << LEN_W) - 1, PAT_LIM + 1));
            else if (len_sel < 6)
                len_val = LEN_W'($urandom_range(PAT_LIM - 1, 5));
            else
                len_val = LEN_W'($urandom_range(4, 1));
            for (s = 0; s < PAT_LIM; s++)
                pat[s] = pick_letter(alpha);
            reg_write(REG_PATTERN_LEN, APB_DATA_W'(len_val));
            for (t = 0; t < PAT_REG_COUNT; t++)
            begin
                for (s = 0; s < LETTERS_PER_REG; s++)
                    regv[s * LETTER_W +: LETTER_W] = pat[t * LETTERS_PER_REG + s];
                reg_write(REG_IDX_W'(REG_LETTERS_0 + t), APB_DATA_W'(regv));
            end
            if ($urandom_range(3, 0) == 0)
                reg_write(REG_IDX_W'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)),
                          {$urandom, $urandom});
            n     = effective_len(len_val);
            texts = $urandom_range(6, 1);
            for (t = 0; t < texts; t++)
            begin
                text.delete();
                text_len = $urandom_range(3 * n + 8, 1);
                while (text.size() < text_len)
                begin
                    if ($urandom_range(2, 0) == 0)
                        for (s = 0; s < n; s++)
                            text.push_back(pat[s]);
                    else
                        text.push_back(pick_letter(alpha));
                end
                // a text left open carries its window into the next setting
                keep_open = (t == texts - 1) && ($urandom_range(3, 0) == 0);
                for (s = 0; s < text.size(); s++)
                    send_letter(text[s], (s == text.size() - 1) && !keep_open);
                sent += text.size();
            end
        end
        wait_idle();
    endtask

    initial
    begin
        reset_model();
        rst_n                  <= 1'b0;
        psel                   <= 1'b0;
        penable                <= 1'b0;
        pwrite                 <= 1'b0;
        paddr                  <= '0;
        pwdata                 <= '0;
        letter_if.valid        <= 1'b0;
        letter_if.letter       <= '0;
        letter_if.final_letter <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_pattern();
        test_register_access();
        test_short_text_and_overlap();
        test_zero_length();
        test_high_codes();
        test_config_mid_text();
        test_random_texts();

        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
